/* src/daf_pkg.sv */
`timescale 1ns / 1ps

package daf_pkg;

   localparam int IP_FIELD_BYTES_DEFAULT = 16;

   localparam logic [1:0] CMD_TIME   = 2'd0;
   localparam logic [1:0] CMD_ENERGY = 2'd1;
   localparam logic [1:0] CMD_IPV4   = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   // twelve bcd digits: time uses 4:0 and energy 5:0 (0 = units),
   // ipv4 octet n uses digits 3n+2 down to 3n
   localparam int NUM_DIGITS = 12;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]                       command;
      logic [NUM_DIGITS-1:0][3:0]       digits;
   } daf_entry_type;

endpackage

/* src/daf_front.sv */
`timescale 1ns / 1ps

module daf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [31:0]            req_value,
   output logic                   push_valid,
   output daf_pkg::daf_entry_type push_entry,
   input  logic                   queue_full
);
   import daf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam logic [31:0] ENERGY_MAX = 32'd999999;

   logic [1:0]                 state_ff, state_in;
   logic [1:0]                 cmd_ff, cmd_in;
   logic [19:0]                rem_ff, rem_in;
   logic [2:0]                 k_ff, k_in;
   logic [NUM_DIGITS-1:0][3:0] digits_ff, digits_in;

   logic        accept;
   logic        push_fire;
   logic [3:0]  step_digit;
   logic [19:0] step_sub;

   // d times ten to the k; d is a constant at every call site
   function automatic logic [19:0] dec_weight(input logic [2:0] k, input logic [3:0] d);
      logic [19:0] w;
      case (k)
         3'd0:    w = 20'd1;
         3'd1:    w = 20'd10;
         3'd2:    w = 20'd100;
         3'd3:    w = 20'd1000;
         3'd4:    w = 20'd10000;
         3'd5:    w = 20'd100000;
         default: w = 20'd0;
      endcase
      return 20'(w * 20'(d));
   endfunction

   // one octet to hundreds, tens and units
   function automatic logic [11:0] octet_bcd(input logic [7:0] b);
      logic [3:0] h;
      logic [3:0] t;
      logic [7:0] r;
      logic [7:0] u;
      h = (b >= 8'd200) ? 4'd2 : ((b >= 8'd100) ? 4'd1 : 4'd0);
      r = (b >= 8'd200) ? 8'(b - 8'd200) : ((b >= 8'd100) ? 8'(b - 8'd100) : b);
      t = 4'd0;
      for (int d = 1; d < 10; d++) begin
         if (r >= 8'(d * 10)) begin
            t = 4'(d);
         end
      end
      u = 8'(r - 8'({4'd0, t} * 8'd10));
      return {h, t, u[3:0]};
   endfunction

   assign push_fire = (state_ff == ST_PUSH) && !queue_full;
   assign req_stall = (state_ff != ST_IDLE) && !push_fire;
   assign accept    = req_valid && !req_stall;

   assign push_valid         = (state_ff == ST_PUSH);
   assign push_entry.command = cmd_ff;
   assign push_entry.digits  = digits_ff;

   // one decimal digit per cycle: compare against all nine multiples at once
   always_comb begin
      step_digit = 4'd0;
      step_sub   = 20'd0;
      for (int d = 1; d < 10; d++) begin
         if (rem_ff >= dec_weight(k_ff, 4'(d))) begin
            step_digit = 4'(d);
            step_sub   = dec_weight(k_ff, 4'(d));
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      digits_in = digits_ff;

      if (state_ff == ST_CONV) begin
         digits_in[{1'b0, k_ff}] = step_digit;
         rem_in = 20'(rem_ff - step_sub);
         if (k_ff == 3'd0) begin
            state_in = ST_PUSH;
         end else begin
            k_in = 3'(k_ff - 3'd1);
         end
      end

      if (push_fire) begin
         state_in = ST_IDLE;
      end

      if (accept) begin
         cmd_in = req_command;
         unique case (req_command)
            CMD_TIME: begin
               rem_in   = {4'd0, req_value[15:0]};
               k_in     = 3'd4;
               state_in = ST_CONV;
            end
            CMD_ENERGY: begin
               rem_in   = (req_value > ENERGY_MAX) ? ENERGY_MAX[19:0] : req_value[19:0];
               k_in     = 3'd5;
               state_in = ST_CONV;
            end
            CMD_IPV4: begin
               digits_in = {octet_bcd(req_value[31:24]), octet_bcd(req_value[23:16]),
                            octet_bcd(req_value[15:8]), octet_bcd(req_value[7:0])};
               state_in  = ST_PUSH;
            end
            default: begin
               // unused command is dropped without output
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff    <= cmd_in;
      rem_ff    <= rem_in;
      k_ff      <= k_in;
      digits_ff <= digits_in;
   end

endmodule

/* src/daf_queue.sv */
`timescale 1ns / 1ps

module daf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  daf_pkg::daf_entry_type push_entry,
   output logic                   queue_full,
   input  logic                   pop,
   output logic                   queue_empty,
   output daf_pkg::daf_entry_type pop_entry
);
   import daf_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   daf_entry_type    slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign queue_full  = (count_ff == CW'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign do_push     = push_valid && !queue_full;
   assign do_pop      = pop && !queue_empty;
   assign pop_entry   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/daf_back.sv */
`timescale 1ns / 1ps

module daf_back #(
   parameter int IP_FIELD_BYTES = daf_pkg::IP_FIELD_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  daf_pkg::daf_entry_type pop_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_char_byte,
   output logic                   rsp_last
);
   import daf_pkg::*;

   localparam int CW = $clog2(IP_FIELD_BYTES);

   localparam logic [1:0] PH_DIGIT = 2'd0;
   localparam logic [1:0] PH_DOT   = 2'd1;
   localparam logic [1:0] PH_NUL   = 2'd2;

   logic                       busy_ff, busy_in;
   logic [1:0]                 cmd_ff, cmd_in;
   logic [NUM_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic [2:0]                 pos_ff, pos_in;
   logic [1:0]                 oct_ff, oct_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_char_byte_ff, rsp_char_byte_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic        emit;
   logic [3:0]  cur_idx;
   logic [1:0]  next_oct;
   logic [3:0]  next_base;
   logic [7:0]  cur_byte;
   logic        cur_last;
   logic [2:0]  load_pos;

   // position of the leading digit of an octet
   function automatic logic [2:0] oct_top(input logic [3:0] h, input logic [3:0] t);
      return (h != 4'd0) ? 3'd2 : ((t != 4'd0) ? 3'd1 : 3'd0);
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign pop      = !busy_ff && !queue_empty;

   assign cur_idx   = (cmd_ff == CMD_IPV4)
                      ? 4'({1'b0, oct_ff, 1'b0} + {2'b0, oct_ff} + {1'b0, pos_ff})
                      : {1'b0, pos_ff};
   assign next_oct  = 2'(oct_ff - 2'd1);
   assign next_base = 4'({1'b0, next_oct, 1'b0} + {2'b0, next_oct});

   // leading zero suppression picks the starting digit at load
   always_comb begin
      load_pos = 3'd0;
      case (pop_entry.command)
         CMD_TIME: begin
            load_pos = (pop_entry.digits[4] != 4'd0) ? 3'd4 :
                       ((pop_entry.digits[3] != 4'd0) ? 3'd3 : 3'd2);
         end
         CMD_ENERGY: begin
            for (int i = 1; i < 6; i++) begin
               if (pop_entry.digits[i] != 4'd0) begin
                  load_pos = 3'(i);
               end
            end
         end
         CMD_IPV4: begin
            load_pos = oct_top(pop_entry.digits[11], pop_entry.digits[10]);
         end
         default: begin
            load_pos = 3'd0;
         end
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      cmd_in    = cmd_ff;
      digits_in = digits_ff;
      pos_in    = pos_ff;
      oct_in    = oct_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      cur_byte  = CHAR_NUL;
      cur_last  = 1'b0;

      unique case (phase_ff)
         PH_DIGIT: begin
            cur_byte = 8'(CHAR_ZERO + {4'd0, digits_ff[cur_idx]});
            case (cmd_ff)
               CMD_TIME: begin
                  if (pos_ff == 3'd2) begin
                     phase_in = PH_DOT;
                  end else if (pos_ff == 3'd0) begin
                     phase_in = PH_NUL;
                  end else begin
                     pos_in = 3'(pos_ff - 3'd1);
                  end
               end
               CMD_IPV4: begin
                  if (pos_ff == 3'd0) begin
                     phase_in = (oct_ff == 2'd0) ? PH_NUL : PH_DOT;
                  end else begin
                     pos_in = 3'(pos_ff - 3'd1);
                  end
               end
               default: begin
                  if (pos_ff == 3'd0) begin
                     phase_in = PH_NUL;
                  end else begin
                     pos_in = 3'(pos_ff - 3'd1);
                  end
               end
            endcase
         end
         PH_DOT: begin
            cur_byte = CHAR_DOT;
            phase_in = PH_DIGIT;
            if (cmd_ff == CMD_IPV4) begin
               oct_in = next_oct;
               pos_in = oct_top(digits_ff[4'(next_base + 4'd2)],
                                digits_ff[4'(next_base + 4'd1)]);
            end else begin
               pos_in = 3'd1;
            end
         end
         PH_NUL: begin
            cur_byte = CHAR_NUL;
            // ipv4 pads with nul up to the fixed field width
            cur_last = (cmd_ff == CMD_IPV4) ? (count_ff == CW'(IP_FIELD_BYTES - 1)) : 1'b1;
         end
         default: begin
            cur_byte = CHAR_NUL;
            cur_last = 1'b1;
         end
      endcase

      if (emit) begin
         count_in = CW'(count_ff + 1'b1);
         if (cur_last) begin
            busy_in = 1'b0;
         end
      end else begin
         cmd_in    = cmd_ff;
         pos_in    = pos_ff;
         oct_in    = oct_ff;
         phase_in  = phase_ff;
      end

      if (pop) begin
         busy_in   = 1'b1;
         cmd_in    = pop_entry.command;
         digits_in = pop_entry.digits;
         pos_in    = load_pos;
         oct_in    = 2'd3;
         phase_in  = PH_DIGIT;
         count_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_char_byte_in = rsp_char_byte_ff;
      rsp_last_in      = rsp_last_ff;
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_char_byte_in = cur_byte;
         rsp_last_in      = cur_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_byte = rsp_char_byte_ff;
   assign rsp_last      = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_DIGIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff           <= cmd_in;
      digits_ff        <= digits_in;
      pos_ff           <= pos_in;
      oct_ff           <= oct_in;
      count_ff         <= count_in;
      rsp_char_byte_ff <= rsp_char_byte_in;
      rsp_last_ff      <= rsp_last_in;
   end

endmodule

/* src/decimal_ascii_formatter.sv */
`timescale 1ns / 1ps

// decimal ascii formatter
// request channel (req_valid / req_stall): one transaction per format job,
// req_command selects time (hundredths), energy (integer) or ipv4 dotted,
// req_value carries the binary value. command 3 is dropped with no output.
// response channel (rsp_valid / rsp_stall): one ascii byte per transaction,
// rsp_last marks the final byte of a job's string.
// the front converts the value to bcd, one decimal digit per cycle for time
// and energy and all at once for ipv4, and hands it to a two-entry queue;
// the back serializes the string one byte per cycle while rsp_stall is low.
// with the back idle, a job passes the front, the queue and the back's load
// before the output register raises rsp_valid.
// the back loads a job and then emits its string, IP_FIELD_BYTES bytes for
// ipv4 and up to seven bytes with the nul for time and energy; the front keeps
// converting while the back emits, so jobs overlap.
// reset clears the control state and drops any job in flight.
// req_stall is high while the front converts. when rsp_stall is high the held
// byte stays put; the queue then fills and req_stall also stays high once the
// front has a converted job it cannot hand over.
module decimal_ascii_formatter #(
   parameter int IP_FIELD_BYTES = daf_pkg::IP_FIELD_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_byte,
   output logic        rsp_last
);
   import daf_pkg::*;

   logic          push_valid;
   daf_entry_type push_entry;
   logic          queue_full;
   logic          queue_empty;
   logic          pop;
   daf_entry_type pop_entry;

   daf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_value   (req_value),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .queue_full  (queue_full)
   );

   daf_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .queue_full  (queue_full),
      .pop         (pop),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry)
   );

   daf_back #(
      .IP_FIELD_BYTES (IP_FIELD_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_byte (rsp_char_byte),
      .rsp_last      (rsp_last)
   );

endmodule
